FILE: sv/bezier_point_evaluator_unit_defines.svh
// ----------------------------------------------------------------------------
// Bezier point evaluator assertion macros
// Shared concurrent assertion forms used by the evaluator RTL.
// ----------------------------------------------------------------------------
`ifndef BEZIER_POINT_EVALUATOR_UNIT_DEFINES_SVH
`define BEZIER_POINT_EVALUATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define BZPE_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bzpe assertion failed");

// next-cycle implication
`define BZPE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bzpe assertion failed");

`endif

FILE: sv/bzpe_pkg.sv
// ----------------------------------------------------------------------------
// Bezier point evaluator package
// Widths, word types and pipeline control types for the evaluator.
// ----------------------------------------------------------------------------
package bzpe_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int T_FRAC_BITS = 16;
   localparam int T_WIDTH     = T_FRAC_BITS + 1;
   // (coord+1) x (t+1 signed) product
   localparam int PROD_WIDTH  = COORD_WIDTH + 1 + T_WIDTH + 1;
   localparam int STEP_WIDTH  = PROD_WIDTH - T_FRAC_BITS;
   // three lerp levels, two register stages each
   localparam int NUM_STAGES  = 6;
   localparam int T_STAGES    = 4;
   localparam int ACT_STAGES  = 2;

   localparam logic [T_WIDTH-1:0] T_ONE = T_WIDTH'(1) << T_FRAC_BITS;
   localparam logic signed [PROD_WIDTH-1:0] ROUND_HALF =
      PROD_WIDTH'(1) << (T_FRAC_BITS - 1);

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic [T_WIDTH-1:0]            t_type;

   typedef struct packed {
      coord_type   p0_x;
      coord_type   p0_y;
      coord_type   p1_x;
      coord_type   p1_y;
      coord_type   p2_x;
      coord_type   p2_y;
      coord_type   p3_x;
      coord_type   p3_y;
      logic [2:0]  point_count;
      t_type       param_t;
   } req_word_type;

   typedef struct packed {
      coord_type curve_x;
      coord_type curve_y;
   } rsp_word_type;

   typedef struct packed {
      logic en_mul;
      logic en_add;
      logic active;
   } lerp_ctl_type;

   typedef struct packed {
      logic [NUM_STAGES-1:0] en;
      logic                  out_valid;
      t_type                 t_l2;
      logic                  act_l2;
      t_type                 t_l3;
   } pipe_status_type;

endpackage

FILE: sv/bezier_point_evaluator_unit.sv
// ----------------------------------------------------------------------------
// Bezier point evaluator
// de Casteljau evaluation of a linear, quadratic or cubic curve point in
// Q16.16 over three pipelined lerp levels.
// ----------------------------------------------------------------------------
//  channel | ports                              | word
//  --------+------------------------------------+------------------------------
//  request | req_valid, req_ready, req_data     | 4 control points, count, t
//  result  | rsp_valid, rsp_ready, rsp_data     | curve_x, curve_y
//
//  Six register stages (multiply then add for each of three lerp levels);
//  one word accepted per cycle when the output drains.
//  Fewer points skip the leading levels by passing values through.
//  Synchronous reset clears all stage valid bits.
//  A stall at the output fills empty stages first; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module bezier_point_evaluator_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  bzpe_pkg::req_word_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output bzpe_pkg::rsp_word_type rsp_data
);

   bzpe_pkg::pipe_status_type status;
   bzpe_pkg::t_type           t_clamp;
   logic                      act1;
   logic                      act2;
   bzpe_pkg::coord_type       pts_x [4];
   bzpe_pkg::coord_type       pts_y [4];
   bzpe_pkg::coord_type       l1_x  [3];
   bzpe_pkg::coord_type       l1_y  [3];
   bzpe_pkg::coord_type       l2_x  [2];
   bzpe_pkg::coord_type       l2_y  [2];
   bzpe_pkg::coord_type       l3_x;
   bzpe_pkg::coord_type       l3_y;
   bzpe_pkg::lerp_ctl_type    ctl1;
   bzpe_pkg::lerp_ctl_type    ctl2;
   bzpe_pkg::lerp_ctl_type    ctl3;

   assign t_clamp = (req_data.param_t > bzpe_pkg::T_ONE) ? bzpe_pkg::T_ONE
                                                          : req_data.param_t;
   // counts 0/1 act as 2, 5..7 as 4
   assign act1 = req_data.point_count[2];
   assign act2 = req_data.point_count[2]
              || (req_data.point_count[1] && req_data.point_count[0]);

   assign pts_x[0] = req_data.p0_x;
   assign pts_x[1] = req_data.p1_x;
   assign pts_x[2] = req_data.p2_x;
   assign pts_x[3] = req_data.p3_x;
   assign pts_y[0] = req_data.p0_y;
   assign pts_y[1] = req_data.p1_y;
   assign pts_y[2] = req_data.p2_y;
   assign pts_y[3] = req_data.p3_y;

   bzpe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .req_t     (t_clamp),
      .req_act2  (act2),
      .status    (status)
   );

   assign ctl1 = '{en_mul: status.en[0], en_add: status.en[1], active: act1};
   assign ctl2 = '{en_mul: status.en[2], en_add: status.en[3], active: status.act_l2};
   assign ctl3 = '{en_mul: status.en[4], en_add: status.en[5], active: 1'b1};

   for (genvar j = 0; j < 3; j++) begin : g_l1
      bzpe_lerp u_x (.clock(clock), .a(pts_x[j]), .b(pts_x[j+1]), .t(t_clamp),
                     .ctl(ctl1), .res(l1_x[j]));
      bzpe_lerp u_y (.clock(clock), .a(pts_y[j]), .b(pts_y[j+1]), .t(t_clamp),
                     .ctl(ctl1), .res(l1_y[j]));
   end

   for (genvar j = 0; j < 2; j++) begin : g_l2
      bzpe_lerp u_x (.clock(clock), .a(l1_x[j]), .b(l1_x[j+1]), .t(status.t_l2),
                     .ctl(ctl2), .res(l2_x[j]));
      bzpe_lerp u_y (.clock(clock), .a(l1_y[j]), .b(l1_y[j+1]), .t(status.t_l2),
                     .ctl(ctl2), .res(l2_y[j]));
   end

   bzpe_lerp u_l3_x (.clock(clock), .a(l2_x[0]), .b(l2_x[1]), .t(status.t_l3),
                     .ctl(ctl3), .res(l3_x));
   bzpe_lerp u_l3_y (.clock(clock), .a(l2_y[0]), .b(l2_y[1]), .t(status.t_l3),
                     .ctl(ctl3), .res(l3_y));

   assign rsp_valid        = status.out_valid;
   assign rsp_data.curve_x = l3_x;
   assign rsp_data.curve_y = l3_y;

endmodule

FILE: sv/bzpe_lerp.sv
// ----------------------------------------------------------------------------
// Bezier point evaluator lerp lane
// a + round_half_up((b - a) * t), two register stages: multiply, then add.
// An inactive lane passes a through unchanged.
// ----------------------------------------------------------------------------
module bzpe_lerp (
   input  logic                  clock,
   input  bzpe_pkg::coord_type    a,
   input  bzpe_pkg::coord_type    b,
   input  bzpe_pkg::t_type        t,
   input  bzpe_pkg::lerp_ctl_type ctl,
   output bzpe_pkg::coord_type    res
);

   typedef logic signed [bzpe_pkg::PROD_WIDTH-1:0] prod_type;

   logic signed [bzpe_pkg::COORD_WIDTH:0]      diff;
   logic signed [bzpe_pkg::PROD_WIDTH-1:0]     prod_in;
   logic signed [bzpe_pkg::PROD_WIDTH-1:0]     prod_ff;
   bzpe_pkg::coord_type                         a_ff;
   logic                                        act_ff;
   logic signed [bzpe_pkg::PROD_WIDTH-1:0]     rnd_sum;
   logic signed [bzpe_pkg::STEP_WIDTH-1:0]     step_val;
   logic signed [bzpe_pkg::STEP_WIDTH-1:0]     total;
   bzpe_pkg::coord_type                         res_in;
   bzpe_pkg::coord_type                         res_ff;

   assign diff    = $signed({b[bzpe_pkg::COORD_WIDTH-1], b})
                  - $signed({a[bzpe_pkg::COORD_WIDTH-1], a});
   assign prod_in = prod_type'(diff) * prod_type'($signed({1'b0, t}));

   always_ff @(posedge clock) begin
      if (ctl.en_mul) begin
         prod_ff <= prod_in;
         a_ff    <= a;
         act_ff  <= ctl.active;
      end
   end

   // upper bits of two's complement give floor of the shift
   assign rnd_sum  = prod_ff + bzpe_pkg::ROUND_HALF;
   assign step_val = rnd_sum[bzpe_pkg::PROD_WIDTH-1:bzpe_pkg::T_FRAC_BITS];
   assign total    = step_val + {{(bzpe_pkg::STEP_WIDTH-bzpe_pkg::COORD_WIDTH)
                                  {a_ff[bzpe_pkg::COORD_WIDTH-1]}}, a_ff};
   // result stays inside the hull of a and b, so truncation is exact
   assign res_in   = act_ff ? total[bzpe_pkg::COORD_WIDTH-1:0] : a_ff;

   always_ff @(posedge clock) begin
      if (ctl.en_add) begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule

FILE: sv/bzpe_ctrl.sv
// ----------------------------------------------------------------------------
// Bezier point evaluator pipeline control
// Per-stage valid bits, stage enables and the t / level flags that travel
// alongside the data.
// ----------------------------------------------------------------------------
`include "bezier_point_evaluator_unit_defines.svh"

module bzpe_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       rsp_ready,
   input  bzpe_pkg::t_type            req_t,
   input  logic                       req_act2,
   output bzpe_pkg::pipe_status_type  status
);

   logic [bzpe_pkg::NUM_STAGES-1:0] valid_ff;
   logic [bzpe_pkg::NUM_STAGES-1:0] valid_in;
   logic [bzpe_pkg::NUM_STAGES-1:0] en_w;
   bzpe_pkg::t_type                 t_ff  [bzpe_pkg::T_STAGES];
   logic [bzpe_pkg::ACT_STAGES-1:0] act2_ff;

   // a stage loads when empty or when the stage after it moves
   always_comb begin
      en_w[bzpe_pkg::NUM_STAGES-1] = !valid_ff[bzpe_pkg::NUM_STAGES-1] || rsp_ready;
      for (int k = bzpe_pkg::NUM_STAGES - 2; k >= 0; k--) begin
         en_w[k] = !valid_ff[k] || en_w[k+1];
      end
      valid_in[0] = req_valid;
      for (int k = 1; k < bzpe_pkg::NUM_STAGES; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < bzpe_pkg::NUM_STAGES; k++) begin
            if (en_w[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_w[0]) begin
         t_ff[0]    <= req_t;
         act2_ff[0] <= req_act2;
      end
      if (en_w[1]) begin
         act2_ff[1] <= act2_ff[0];
      end
      for (int k = 1; k < bzpe_pkg::T_STAGES; k++) begin
         if (en_w[k]) begin
            t_ff[k] <= t_ff[k-1];
         end
      end
   end

   assign req_ready        = en_w[0];
   assign status.en        = en_w;
   assign status.out_valid = valid_ff[bzpe_pkg::NUM_STAGES-1];
   assign status.t_l2      = t_ff[1];
   assign status.act_l2    = act2_ff[1];
   assign status.t_l3      = t_ff[3];

   `BZPE_ASSERT_NEXT(a_accept_enters, clock, reset, req_valid && req_ready, valid_ff[0])
   `BZPE_ASSERT_NEXT(a_mid_stall_holds, clock, reset, valid_ff[2] && !en_w[3], valid_ff[2])
   `BZPE_ASSERT_IMPL(a_t_clamped, clock, reset, valid_ff[0], t_ff[0] <= bzpe_pkg::T_ONE)
   `BZPE_ASSERT_IMPL(a_ready_when_empty, clock, reset, valid_ff == '0, req_ready)

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bezier point evaluator testbench
// Drives control point sets through the request channel with random gaps
// and result stalls. Each accepted word is scored against a hand-typed
// expectation or a de Casteljau model kept here in Q16.16 with round-half-up.
// ----------------------------------------------------------------------------
module tb;

   typedef bzpe_pkg::coord_type    coord_type;
   typedef bzpe_pkg::t_type        t_type;
   typedef bzpe_pkg::req_word_type req_word_type;
   typedef bzpe_pkg::rsp_word_type rsp_word_type;

   localparam int    CLEAR_WAIT   = 20;    // cycles after the last result
   localparam int    STALL_LIMIT  = 2000;  // cycles with no word moving
   localparam int    WORDS_PHASE  = 330;
   localparam int    NUM_ROWS     = 21;
   localparam int    MAX_REPORTS  = 10;
   localparam longint ONE_T       = longint'(1) << bzpe_pkg::T_FRAC_BITS;
   localparam longint HALF_T      = longint'(1) << (bzpe_pkg::T_FRAC_BITS - 1);
   localparam longint FRAC_MASK   = ONE_T - 1;

   localparam coord_type C_MAX  = coord_type'(32'h7FFF_FFFF);
   localparam coord_type C_MIN  = coord_type'(32'h8000_0000);
   localparam coord_type Q_ONE  = coord_type'(32'h0001_0000);
   localparam coord_type Q_NEG  = coord_type'(32'hFFFF_0000);
   localparam coord_type LSB_P  = coord_type'(32'h0000_0001);
   localparam coord_type LSB_N  = coord_type'(32'hFFFF_FFFF);
   localparam t_type     T_HALF_STEP = t_type'(32768);
   localparam t_type     T_PAST_ONE  = t_type'(17'h1FFFF);

   typedef struct {
      req_word_type word;
      logic         typed;
      rsp_word_type want;
   } stim_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_data;

   // hand-typed expectation riding along with the word on the bus
   logic         hand_typed = 1'b0;
   rsp_word_type typed_point = '0;

   rsp_word_type expected_points[$];
   rsp_word_type want_point;
   stim_row_type dir_rows [NUM_ROWS];
   int           words_sent = 0;
   int           points_seen = 0;
   int           mismatches = 0;
   int           quiet_cycles = 0;
   int           send_idle_pct = 0;
   int           rsp_stall_pct = 0;
   int           degree_words [3] = '{0, 0, 0};

   bezier_point_evaluator_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // a*(1-t) + b*t, rounded half up to Q16.16
   function automatic longint lerp_q16(longint a, longint b, longint t);
      longint diff, mag, whole, part;
      diff  = b - a;
      mag   = (diff < 0) ? -diff : diff;
      whole = (mag >>> bzpe_pkg::T_FRAC_BITS) * t;
      part  = (mag & FRAC_MASK) * t;
      if (diff >= 0)
         return a + whole + ((part + HALF_T) >>> bzpe_pkg::T_FRAC_BITS);
      return a - whole + ((HALF_T - part) >>> bzpe_pkg::T_FRAC_BITS);
   endfunction

   function automatic coord_type curve_axis(longint c0, longint c1, longint c2,
                                            longint c3, int n, longint t);
      longint pt [4];
      pt[0] = c0; pt[1] = c1; pt[2] = c2; pt[3] = c3;
      for (int lvl = 1; lvl < n; lvl++)
         for (int j = 0; j + lvl < n; j++)
            pt[j] = lerp_q16(pt[j], pt[j+1], t);
      return coord_type'(pt[0]);
   endfunction

   function automatic int degree_points(logic [2:0] count);
      if (count < 2)
         return 2;
      if (count > 4)
         return 4;
      return int'(count);
   endfunction

   function automatic rsp_word_type curve_point(req_word_type w);
      rsp_word_type r;
      int           n;
      longint       t;
      n = degree_points(w.point_count);
      t = longint'(w.param_t);
      if (t > ONE_T)
         t = ONE_T;
      r.curve_x = curve_axis(w.p0_x, w.p1_x, w.p2_x, w.p3_x, n, t);
      r.curve_y = curve_axis(w.p0_y, w.p1_y, w.p2_y, w.p3_y, n, t);
      return r;
   endfunction

   function automatic stim_row_type stim_row(
      coord_type x0, coord_type y0, coord_type x1, coord_type y1,
      coord_type x2, coord_type y2, coord_type x3, coord_type y3,
      logic [2:0] n, t_type t, logic typed, coord_type wx, coord_type wy);
      stim_row_type r;
      r.word = '{p0_x: x0, p0_y: y0, p1_x: x1, p1_y: y1, p2_x: x2, p2_y: y2,
                 p3_x: x3, p3_y: y3, point_count: n, param_t: t};
      r.typed = typed;
      r.want  = '{curve_x: wx, curve_y: wy};
      return r;
   endfunction

   function automatic coord_type random_coord();
      case ($urandom_range(9))
         0: return C_MAX;
         1: return C_MIN;
         2, 3: return coord_type'(int'($urandom_range(32'h1F_FFFF)) - 32'h10_0000);
         default: return coord_type'($urandom());
      endcase
   endfunction

   function automatic req_word_type random_request();
      req_word_type w;
      w.p0_x = random_coord(); w.p0_y = random_coord();
      w.p1_x = random_coord(); w.p1_y = random_coord();
      w.p2_x = random_coord(); w.p2_y = random_coord();
      w.p3_x = random_coord(); w.p3_y = random_coord();
      if ($urandom_range(99) < 15)
         w.point_count = 3'($urandom_range(7));
      else
         w.point_count = 3'($urandom_range(4, 2));
      case ($urandom_range(9))
         0: w.param_t = '0;
         1: w.param_t = bzpe_pkg::T_ONE;
         2: w.param_t = t_type'($urandom_range(131071));
         default: w.param_t = t_type'($urandom_range(65536));
      endcase
      return w;
   endfunction

   task automatic flag_mismatch(input rsp_word_type want, input rsp_word_type got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("mismatch on result %0d: x exp %0d got %0d, y exp %0d got %0d",
                  points_seen, want.curve_x, got.curve_x, want.curve_y, got.curve_y);
   endtask

   // scoreboard: results are checked before this edge's request is queued
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_points.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected result %0d: x %0d y %0d",
                        points_seen, rsp_data.curve_x, rsp_data.curve_y);
         end else begin
            want_point = expected_points.pop_front();
            if (rsp_data.curve_x !== want_point.curve_x ||
                rsp_data.curve_y !== want_point.curve_y)
               flag_mismatch(want_point, rsp_data);
         end
         points_seen <= points_seen + 1;
      end
      if (!reset && req_valid && req_ready) begin
         expected_points.push_back(hand_typed ? typed_point : curve_point(req_data));
         degree_words[degree_points(req_data.point_count) - 2]++;
         words_sent <= words_sent + 1;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(negedge clock)
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);

   task automatic send_word(input req_word_type w, input logic typed,
                            input rsp_word_type want);
      int target;
      target = words_sent + 1;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_data    <= w;
      hand_typed  <= typed;
      typed_point <= want;
      do
         @(negedge clock);
      while (words_sent != target);
   endtask

   // hold the sender off until every result is back
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_points.size() != 0)
         @(negedge clock);
   endtask

   initial begin
      dir_rows = '{
         stim_row('0, '0, '0, '0, '0, '0, '0, '0, 3'd2, '0, 1'b1, '0, '0),
         stim_row(C_MAX, C_MIN, C_MIN, C_MAX, '0, '0, '0, '0, 3'd2, '0,
                  1'b1, C_MAX, C_MIN),
         stim_row(C_MAX, C_MIN, C_MIN, C_MAX, '0, '0, '0, '0, 3'd2, bzpe_pkg::T_ONE,
                  1'b1, C_MIN, C_MAX),
         stim_row(Q_ONE, Q_NEG, C_MAX, C_MIN, C_MIN, C_MAX, Q_ONE, Q_ONE, 3'd3,
                  bzpe_pkg::T_ONE, 1'b1, C_MIN, C_MAX),
         stim_row(Q_ONE, Q_NEG, C_MAX, C_MIN, C_MIN, C_MAX, Q_ONE, Q_ONE, 3'd4,
                  bzpe_pkg::T_ONE, 1'b1, Q_ONE, Q_ONE),
         // counts below two fall back to linear
         stim_row(Q_ONE, Q_NEG, C_MAX, C_MIN, C_MIN, C_MAX, Q_ONE, Q_ONE, 3'd0,
                  bzpe_pkg::T_ONE, 1'b1, C_MAX, C_MIN),
         stim_row(Q_ONE, Q_NEG, C_MAX, C_MIN, C_MIN, C_MAX, Q_ONE, Q_ONE, 3'd1,
                  bzpe_pkg::T_ONE, 1'b1, C_MAX, C_MIN),
         // counts above four fall back to cubic
         stim_row(Q_ONE, Q_NEG, C_MAX, C_MIN, C_MIN, C_MAX, Q_ONE, Q_ONE, 3'd5,
                  bzpe_pkg::T_ONE, 1'b1, Q_ONE, Q_ONE),
         stim_row(Q_ONE, Q_NEG, C_MAX, C_MIN, C_MIN, C_MAX, Q_ONE, Q_ONE, 3'd7,
                  bzpe_pkg::T_ONE, 1'b1, Q_ONE, Q_ONE),
         stim_row(Q_ONE, Q_NEG, C_MAX, C_MIN, C_MIN, C_MAX, Q_ONE, Q_ONE, 3'd6,
                  '0, 1'b1, Q_ONE, Q_NEG),
         // t past one clamps to one; then a curve of coincident points
         stim_row(Q_ONE, Q_NEG, C_MAX, C_MIN, C_MIN, C_MAX, Q_ONE, Q_ONE, 3'd4,
                  T_PAST_ONE, 1'b1, Q_ONE, Q_ONE),
         stim_row(Q_ONE, Q_NEG, C_MAX, C_MIN, C_MIN, C_MAX, Q_ONE, Q_ONE, 3'd3,
                  t_type'(65537), 1'b1, C_MIN, C_MAX),
         stim_row(C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, 3'd4,
                  t_type'(12345), 1'b1, C_MAX, C_MIN),
         // half-lsb ties, both directions, then extreme points, all model-checked
         stim_row('0, '0, LSB_P, LSB_N, '0, '0, '0, '0, 3'd2, T_HALF_STEP,
                  1'b0, '0, '0),
         stim_row('0, '0, LSB_N, LSB_P, '0, '0, '0, '0, 3'd2, T_HALF_STEP,
                  1'b0, '0, '0),
         stim_row(Q_ONE, Q_NEG, C_MAX, C_MIN, C_MIN, C_MAX, Q_ONE, Q_ONE, 3'd2,
                  T_HALF_STEP, 1'b0, '0, '0),
         stim_row(Q_ONE, Q_NEG, C_MAX, C_MIN, C_MIN, C_MAX, Q_ONE, Q_ONE, 3'd3,
                  T_HALF_STEP, 1'b0, '0, '0),
         stim_row(Q_ONE, Q_NEG, C_MAX, C_MIN, C_MIN, C_MAX, Q_ONE, Q_ONE, 3'd4,
                  T_HALF_STEP, 1'b0, '0, '0),
         stim_row(C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, 3'd4,
                  t_type'(1), 1'b0, '0, '0),
         stim_row(C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, 3'd4,
                  t_type'(65535), 1'b0, '0, '0),
         stim_row(C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, 3'd3,
                  t_type'(21845), 1'b0, '0, '0)
      };

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 7;
      rsp_stall_pct = 65;
      foreach (dir_rows[i])
         send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);
      drain();

      // sender dense / receiver busy, then swapped, then full rate
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 65 : 0;
         rsp_stall_pct = (phase == 0) ? 65 : (phase == 1) ? 7 : 0;
         for (int k = 0; k < WORDS_PHASE; k++)
            send_word(random_request(), 1'b0, '0);
         drain();
      end

      repeat (CLEAR_WAIT) @(negedge clock);
      if (expected_points.size() != 0)
         mismatches += expected_points.size();

      $display("covered %0d words (%0d directed): %0d linear, %0d quadratic, %0d cubic",
               words_sent, NUM_ROWS, degree_words[0], degree_words[1], degree_words[2]);
      $display("results checked: %0d, mismatches: %0d", points_seen, mismatches);
      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
